// File: rtl/core/edh_pkg.sv
package edh_pkg;

    localparam int DECAY_W     = 16;
    localparam int THR_W       = 17;
    localparam int AVG_OUT_W   = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [DECAY_W-1:0] DECAY_RESET    = 16'd58982;
    localparam logic [THR_W-1:0]   THR_HIGH_RESET = 17'd52429;
    localparam logic [THR_W-1:0]   THR_LOW_RESET  = 17'd13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_FACTOR     = 3'd0,
        CFG_THRESHOLD_HIGH   = 3'd1,
        CFG_THRESHOLD_LOW    = 3'd2,
        CFG_PIN_POLARITY_INV = 3'd3,
        CFG_EVENTS_ENABLED   = 3'd4
    } cfg_index_t;

endpackage

// File: rtl/core/edh_sample_if.sv
interface edh_sample_if;
    logic valid;
    logic ready;
    logic raw_pin_level;

    modport source (output valid, output raw_pin_level, input ready);
    modport sink (input valid, input raw_pin_level, output ready);
endinterface

// File: rtl/core/edh_result_if.sv
interface edh_result_if
    import edh_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 immediate_good;
    logic                 debounced_good;
    logic                 became_good;
    logic                 became_bad;
    logic [AVG_OUT_W-1:0] average_level;

    modport source (
        output valid, output immediate_good, output debounced_good,
        output became_good, output became_bad, output average_level,
        input ready
    );
    modport sink (
        input valid, input immediate_good, input debounced_good,
        input became_good, input became_bad, input average_level,
        output ready
    );
endinterface

// File: rtl/core/edh_cfg_if.sv
interface edh_cfg_if
    import edh_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ema_debounce_hysteresis_unit.sv
// Power-good debouncer. Each sample transaction carries one raw pin level;
// the block corrects its polarity, folds it into an exponential moving
// average held in unsigned fixed point with FRAC_BITS fraction bits, and
// applies hysteresis against two thresholds to give the debounced status,
// with optional one-shot became_good / became_bad flags. Exactly one result
// transaction follows every sample transaction. One sample is taken per
// clock cycle when the result side keeps up; a result is presented once
// its sample has passed an input register and a result register, and can
// be taken at the following edge. The running average register feeds one
// multiply-add and two compares combinationally, which sets the clock rate
// of the block.
// The first sample after reset seeds the average (zero or one) and the
// status directly and raises no flag. Configuration writes are always taken
// and should be issued only while no sample is in flight; unknown register
// indexes are ignored.
module ema_debounce_hysteresis_unit
    import edh_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    edh_sample_if.sink    sample,
    edh_result_if.source  result,
    edh_cfg_if.sink       cfg
);

    localparam int AVG_W = FRAC_BITS + 1;
    localparam int ACC_W = 2 * AVG_W;
    localparam int SH_W  = ACC_W - FRAC_BITS;
    localparam int CMP_W = (AVG_W > THR_W) ? AVG_W : THR_W;
    localparam int DEC_W = (AVG_W > DECAY_W) ? AVG_W : DECAY_W;

    localparam logic [AVG_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACC_W-1:0] HALF = ACC_W'(ONE) >> 1;

    // Configuration registers.
    logic [DECAY_W-1:0] decay_reg;
    logic [THR_W-1:0]   thr_high_reg;
    logic [THR_W-1:0]   thr_low_reg;
    logic               pol_inv_reg;
    logic               events_en_reg;

    // State of the filter.
    logic [AVG_W-1:0]   avg_reg;
    logic [AVG_W-1:0]   avg_next;
    logic               state_reg;
    logic               state_next;
    logic               seeded_reg;

    // Input register.
    logic               s1_valid_reg;
    logic               s1_level_reg;

    // Result register.
    logic               out_valid_reg;
    logic               out_imm_reg;
    logic               out_deb_reg;
    logic               out_up_reg;
    logic               out_down_reg;
    logic [AVG_W-1:0]   out_avg_reg;
    logic               up_next;
    logic               down_next;

    logic               advance;
    logic               level;
    logic [AVG_W-1:0]   d_sat;
    logic [AVG_W-1:0]   gain;
    logic [ACC_W-1:0]   prod;
    logic [ACC_W-1:0]   term;
    logic [ACC_W-1:0]   acc;
    logic [SH_W-1:0]    shifted;
    logic [AVG_W-1:0]   avg_filt;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= DECAY_RESET;
            thr_high_reg  <= THR_HIGH_RESET;
            thr_low_reg   <= THR_LOW_RESET;
            pol_inv_reg   <= 1'b0;
            events_en_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DECAY_FACTOR:     decay_reg     <= cfg.data[DECAY_W-1:0];
                CFG_THRESHOLD_HIGH:   thr_high_reg  <= cfg.data[THR_W-1:0];
                CFG_THRESHOLD_LOW:    thr_low_reg   <= cfg.data[THR_W-1:0];
                CFG_PIN_POLARITY_INV: pol_inv_reg   <= cfg.data[0];
                CFG_EVENTS_ENABLED:   events_en_reg <= cfg.data[0];
                default:              ;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or
    // is being emptied in the same cycle.
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_level_reg <= sample.raw_pin_level;
        end
    end

    // Filter datapath.
    always_comb
    begin
        level    = s1_level_reg ^ pol_inv_reg;
        d_sat    = (DEC_W'(decay_reg) > DEC_W'(ONE)) ? ONE : AVG_W'(decay_reg);
        gain     = ONE - d_sat;
        prod     = ACC_W'(avg_reg) * ACC_W'(d_sat);
        term     = level ? (ACC_W'(gain) << FRAC_BITS) : '0;
        acc      = prod + term + HALF;
        shifted  = acc[ACC_W-1:FRAC_BITS];
        avg_filt = (shifted > SH_W'(ONE)) ? ONE : shifted[AVG_W-1:0];

        up_next   = 1'b0;
        down_next = 1'b0;
        if (!seeded_reg)
        begin
            avg_next   = level ? ONE : '0;
            state_next = level;
        end
        else
        begin
            avg_next   = avg_filt;
            state_next = state_reg;
            if ((CMP_W'(avg_filt) > CMP_W'(thr_high_reg)) && !state_reg)
            begin
                state_next = 1'b1;
                up_next    = events_en_reg;
            end
            else if ((CMP_W'(avg_filt) < CMP_W'(thr_low_reg)) && state_reg)
            begin
                state_next = 1'b0;
                down_next  = events_en_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg    <= '0;
            state_reg  <= 1'b0;
            seeded_reg <= 1'b0;
        end
        else if (advance)
        begin
            avg_reg    <= avg_next;
            state_reg  <= state_next;
            seeded_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_imm_reg  <= level;
            out_deb_reg  <= state_next;
            out_up_reg   <= up_next;
            out_down_reg <= down_next;
            out_avg_reg  <= avg_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.immediate_good = out_imm_reg;
    assign result.debounced_good = out_deb_reg;
    assign result.became_good    = out_up_reg;
    assign result.became_bad     = out_down_reg;
    assign result.average_level  = AVG_OUT_W'(out_avg_reg);

    // Only one transition can be reported per sample.
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.became_good && result.became_bad))
        else $error("both transition flags raised in one result");

    // The average never leaves the range zero to one.
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        avg_reg <= ONE)
        else $error("running average above one");

    // A stalled result holds the filter state.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> ($stable(avg_reg) && $stable(state_reg)))
        else $error("filter state advanced while the result was stalled");

    // A reported rise must agree with the reported status.
    a_up_good: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.became_good) |-> result.debounced_good)
        else $error("became_good reported with bad status");

endmodule

// File: test/ema_debounce_hysteresis_unit_test.sv
`timescale 1ns / 1ps

module ema_debounce_hysteresis_unit_test;
    import edh_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] FIX_ONE = 64'd1 << FRAC;
    localparam logic [63:0] FIX_HALF = 64'd1 << (FRAC - 1);
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 165;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(CFG_EVENTS_ENABLED + 1);

    typedef struct packed {
        logic                 immediate_good;
        logic                 debounced_good;
        logic                 became_good;
        logic                 became_bad;
        logic [AVG_OUT_W-1:0] average_level;
    } pg_status_t;

    logic clk;
    logic rst_n;

    edh_sample_if sample_bus();
    edh_result_if result_bus();
    edh_cfg_if    cfg_bus();

    ema_debounce_hysteresis_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Register copies and state of the expected debouncer.
    logic [DECAY_W-1:0] cur_decay    = DECAY_RESET;
    logic [THR_W-1:0]   cur_thr_high = THR_HIGH_RESET;
    logic [THR_W-1:0]   cur_thr_low  = THR_LOW_RESET;
    logic               cur_invert   = 1'b0;
    logic               cur_events   = 1'b0;
    logic [AVG_OUT_W-1:0] ema_avg    = '0;
    logic               status_good  = 1'b0;
    logic               avg_seeded   = 1'b0;

    bit         pin_queue[$];
    pg_status_t status_expect_q[$];

    int  queued_cnt = 0;
    int  results_cnt = 0;
    int  error_cnt = 0;
    bit  send_gaps = 1'b0;
    bit  recv_gaps = 1'b0;
    bit  sample_taken = 1'b0;
    bit  result_taken = 1'b0;
    bit  hold_done = 1'b0;
    int  send_wait = 0;
    int  recv_stall = 0;

    always #5 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic pg_status_t advance_debouncer(input logic raw);
        pg_status_t  r;
        logic        lvl;
        logic [63:0] d;
        logic [63:0] acc;
        r = '0;
        lvl = raw ^ cur_invert;
        if (!avg_seeded) begin
            avg_seeded = 1'b1;
            ema_avg = lvl ? AVG_OUT_W'(FIX_ONE) : '0;
            status_good = lvl;
        end
        else begin
            d = (64'(cur_decay) > FIX_ONE) ? FIX_ONE : 64'(cur_decay);
            acc = 64'(ema_avg) * d + (FIX_ONE - d) * (lvl ? FIX_ONE : 64'd0) + FIX_HALF;
            acc = acc >> FRAC;
            if (acc > FIX_ONE)
                acc = FIX_ONE;
            ema_avg = AVG_OUT_W'(acc);
            // Going good is tested first, so only one edge per sample.
            if (acc > 64'(cur_thr_high) && !status_good) begin
                status_good = 1'b1;
                r.became_good = cur_events;
            end
            else if (acc < 64'(cur_thr_low) && status_good) begin
                status_good = 1'b0;
                r.became_bad = cur_events;
            end
        end
        r.immediate_good = lvl;
        r.debounced_good = status_good;
        r.average_level = ema_avg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_cnt++;
        $display("[%0t] result %0d: %s got %0d, expected %0d", $time, results_cnt, what, got,
                 want);
    endtask

    // Monitor: predicts on each accepted sample and checks each accepted result.
    always @(posedge clk)
    begin
        pg_status_t got;
        pg_status_t want;
        if (rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_index_t'(cfg_bus.index))
                    CFG_DECAY_FACTOR:     cur_decay = cfg_bus.data[DECAY_W-1:0];
                    CFG_THRESHOLD_HIGH:   cur_thr_high = cfg_bus.data[THR_W-1:0];
                    CFG_THRESHOLD_LOW:    cur_thr_low = cfg_bus.data[THR_W-1:0];
                    CFG_PIN_POLARITY_INV: cur_invert = cfg_bus.data[0];
                    CFG_EVENTS_ENABLED:   cur_events = cfg_bus.data[0];
                    default: ;
                endcase
            end
            if (sample_bus.valid && sample_bus.ready) begin
                status_expect_q.push_back(advance_debouncer(sample_bus.raw_pin_level));
                sample_taken = 1'b1;
            end
            if (result_bus.valid && result_bus.ready) begin
                got = {result_bus.immediate_good, result_bus.debounced_good,
                       result_bus.became_good, result_bus.became_bad,
                       result_bus.average_level};
                results_cnt++;
                result_taken = 1'b1;
                if (status_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, average", got.average_level, 0);
                end
                else begin
                    want = status_expect_q.pop_front();
                    if (got.immediate_good !== want.immediate_good)
                        report_mismatch("immediate_good", got.immediate_good,
                                        want.immediate_good);
                    if (got.debounced_good !== want.debounced_good)
                        report_mismatch("debounced_good", got.debounced_good,
                                        want.debounced_good);
                    if (got.became_good !== want.became_good)
                        report_mismatch("became_good", got.became_good, want.became_good);
                    if (got.became_bad !== want.became_bad)
                        report_mismatch("became_bad", got.became_bad, want.became_bad);
                    if (got.average_level !== want.average_level)
                        report_mismatch("average_level", got.average_level,
                                        want.average_level);
                end
            end
        end
    end

    // Sample driver: when send_gaps is set, waits a random number of cycles before each new transaction.
    always @(negedge clk)
    begin
        if (!sample_bus.valid || sample_taken) begin
            if (sample_taken) begin
                sample_taken = 1'b0;
                send_wait = send_gaps ? $urandom_range(0, 10) : 0;
            end
            if (send_wait > 0) begin
                sample_bus.valid <= 1'b0;
                send_wait--;
            end
            else if (pin_queue.size() > 0) begin
                sample_bus.raw_pin_level <= pin_queue.pop_front();
                sample_bus.valid <= 1'b1;
            end
            else begin
                sample_bus.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off so the pipeline backs up.
    always @(negedge clk)
    begin
        if (result_taken) begin
            result_taken = 1'b0;
            recv_stall = recv_gaps ? $urandom_range(0, 10) : 0;
        end
        if (!hold_done && results_cnt >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            recv_stall = HOLD_CYCLES;
        end
        if (recv_stall > 0) begin
            result_bus.ready <= 1'b0;
            recv_stall--;
        end
        else begin
            result_bus.ready <= 1'b1;
        end
    end

    function automatic void queue_pin(input bit lvl);
        pin_queue.push_back(lvl);
        queued_cnt++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all(input int decay, input int thr_high, input int thr_low,
                             input bit invert, input bit events);
        // Single-bit registers get random upper data bits, which must be ignored.
        write_reg(CFG_DECAY_FACTOR, {1'($urandom_range(0, 1)), 16'(decay)});
        write_reg(CFG_THRESHOLD_HIGH, CFG_DATA_W'(thr_high));
        write_reg(CFG_THRESHOLD_LOW, CFG_DATA_W'(thr_low));
        write_reg(CFG_PIN_POLARITY_INV, {16'($urandom), invert});
        write_reg(CFG_EVENTS_ENABLED, {16'($urandom), events});
    endtask

    task automatic wait_until_drained();
        while (results_cnt != queued_cnt)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_threshold(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(0, 65536);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic randomize_settings();
        int decay;
        case ($urandom_range(0, 9))
            0: decay = 0;
            1: decay = 65535;
            2: decay = $urandom_range(0, 65535);
            default: decay = $urandom_range(49152, 63000);
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, 7)), CFG_DATA_W'($urandom));
        write_all(decay, pick_threshold(39000, 60000), pick_threshold(5000, 26000),
                  1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
    endtask

    // Mostly steady runs with the odd glitch, so the average actually crosses
    // the thresholds; now and then a burst of pure noise.
    task automatic queue_pin_runs(input int n_items);
        int made;
        int run_len;
        bit lvl;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 7) == 0) begin
                run_len = $urandom_range(1, 12);
                repeat (run_len) queue_pin(1'($urandom_range(0, 1)));
            end
            else begin
                lvl = 1'($urandom_range(0, 1));
                run_len = $urandom_range(4, 48);
                repeat (run_len) queue_pin(($urandom_range(0, 15) == 0) ? !lvl : lvl);
            end
            made += run_len;
        end
    endtask

    initial
    begin
        int k;
        clk = 1'b0;
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.raw_pin_level = 1'b0;
        result_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings; the first sample seeds the average at one.
        send_gaps = 1'($urandom_range(0, 1));
        recv_gaps = 1'($urandom_range(0, 1));
        queue_pin(1'b1);
        queue_pin(1'b1);
        queue_pin(1'b0);
        queue_pin(1'b0);
        wait_until_drained();

        // No retention and unreachable thresholds: the status must hold.
        write_all(0, 65536, 0, 1'b1, 1'b1);
        queue_pin(1'b0);
        queue_pin(1'b1);
        queue_pin(1'b0);
        queue_pin(1'b1);
        wait_until_drained();

        // Crossed thresholds: the status follows each sample's level, with event flags.
        write_all(0, 0, 65536, 1'b0, 1'b1);
        queue_pin(1'b0);
        queue_pin(1'b1);
        queue_pin(1'b0);
        queue_pin(1'b0);
        queue_pin(1'b1);
        queue_pin(1'b1);
        wait_until_drained();

        // Unknown indexes must not disturb anything; events now masked.
        for (k = FIRST_UNUSED_IDX; k <= 7; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        write_reg(CFG_EVENTS_ENABLED, {16'($urandom), 1'b0});
        queue_pin(1'b1);
        queue_pin(1'b0);
        queue_pin(1'b1);
        queue_pin(1'b0);
        wait_until_drained();

        // Largest retention: the average rises by one step per high sample and holds on low ones.
        write_all(65535, THR_HIGH_RESET, THR_LOW_RESET, 1'b0, 1'b1);
        repeat (4) queue_pin(1'b1);
        repeat (2) queue_pin(1'b0);
        wait_until_drained();

        for (k = 0; k < RANDOM_PHASES; k++) begin
            send_gaps = $urandom_range(0, 3) != 0;
            recv_gaps = $urandom_range(0, 3) != 0;
            randomize_settings();
            queue_pin_runs(ITEMS_PER_PHASE);
            wait_until_drained();
        end

        repeat (6) @(posedge clk);
        while (status_expect_q.size() > 0) begin
            report_mismatch("result never arrived, average",
                            -1, status_expect_q[0].average_level);
            void'(status_expect_q.pop_front());
        end
        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
